// ===== design/amab_pkg.sv =====
package amab_pkg;

    // Widths fixed by the word format.
    localparam int RAND_W  = 16;
    localparam int PADDR_W = 5;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_FRAME   = 2'd2;

    // Receive check status.
    localparam logic [1:0] FST_GOOD = 2'd0;
    localparam logic [1:0] FST_BAD  = 2'd1;

    // Received frame types.
    localparam logic [1:0] FTYPE_MSG  = 2'd0;
    localparam logic [1:0] FTYPE_ACK  = 2'd1;
    localparam logic [1:0] FTYPE_NACK = 2'd2;

    // Transmit commands.
    localparam logic [1:0] TX_NONE  = 2'd0;
    localparam logic [1:0] TX_FRAME = 2'd1;
    localparam logic [1:0] TX_ACK   = 2'd2;
    localparam logic [1:0] TX_NACK  = 2'd3;

    // Controller modes, as reported on mac_status.
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_BACKOFF = 2'd1;
    localparam logic [1:0] MODE_ACKWAIT = 2'd2;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_MY_ADDRESS  = 3'd0;
    localparam logic [2:0] REG_MY_GROUP    = 3'd1;
    localparam logic [2:0] REG_WINDOW      = 3'd2;
    localparam logic [2:0] REG_ACK_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_MAX_ATTEMPT = 3'd4;
    localparam logic [2:0] REG_SEED        = 3'd5;

    localparam logic [7:0]        MCAST_ADDR = 8'hFF;
    localparam logic [3:0]        MAX_EXP    = 4'd8;
    localparam logic [RAND_W-1:0] LFSR_TAPS  = 16'hB400;

endpackage

// ===== design/amab_mod_unit.sv =====
module amab_mod_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [amab_pkg::RAND_W-1:0]  dividend,
    input  logic [amab_pkg::RAND_W-1:0]  divisor,
    output logic                         busy,
    output logic                         done,
    output logic [amab_pkg::RAND_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(amab_pkg::RAND_W);

    // Restoring remainder: one dividend bit is shifted in per cycle.
    logic [amab_pkg::RAND_W-1:0] rem_reg, rem_next;
    logic [amab_pkg::RAND_W-1:0] dvd_reg, dvd_next;
    logic [amab_pkg::RAND_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [amab_pkg::RAND_W:0]   shifted;

    always_comb begin
        shifted   = {rem_reg, dvd_reg[amab_pkg::RAND_W-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = amab_pkg::RAND_W'(shifted - {1'b0, dsr_reg});
            end else begin
                rem_next = shifted[amab_pkg::RAND_W-1:0];
            end
            dvd_next = {dvd_reg[amab_pkg::RAND_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(amab_pkg::RAND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy)
        else $error("remainder unit flags done while still busy");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && dsr_reg != '0) |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy)
        else $error("remainder unit started while busy");
`endif

endmodule

// ===== design/aloha_mac_ack_backoff.sv =====
// Channel   | Direction | Handshake        | Word
// ----------+-----------+------------------+-------------------------------------------
// s_*       | in        | s_valid/s_ready  | tick, send request or received frame header
// m_*       | out       | m_valid/m_ready  | one result word per input word
// APB       | in/out    | psel/penable     | six configuration registers at 4*index
//
// Each input word goes from ST_IDLE straight to ST_OUT when no backoff is drawn or the window
// bound is zero, and through ST_DRAW when one is drawn against a nonzero bound: the draw runs
// a 16-step restoring remainder unit, one bit per cycle.
// The result then waits in the output register until m_ready; s_ready stays low
// from acceptance until the result is taken.
// Reset is synchronous on aresetn low and loads the register defaults and the seed.
module aloha_mac_ack_backoff #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic [7:0]                    s_request_dest,
    input  logic [1:0]                    s_frame_status,
    input  logic [7:0]                    s_frame_dest,
    input  logic [7:0]                    s_frame_source,
    input  logic [7:0]                    s_frame_group,
    input  logic [1:0]                    s_frame_type,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_request_accepted,
    output logic [1:0]                    m_tx_kind,
    output logic [7:0]                    m_tx_dest,
    output logic                          m_deliver,
    output logic                          m_gave_up,
    output logic [1:0]                    m_mac_status,
    output logic [3:0]                    m_retry_now,
    output logic [15:0]                   m_error_total,
    output logic [15:0]                   m_ack_total,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [amab_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // The elapsed counter and the 16-bit limits are compared at a common width.
    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_OUT
    } state_t;

    // Configuration registers.
    logic [7:0]  my_address_reg;
    logic [7:0]  my_group_reg;
    logic [7:0]  window_reg;
    logic [15:0] ack_timeout_reg;
    logic [3:0]  max_attempts_reg;
    logic [15:0] seed_reg;

    // Controller state.
    state_t                          state_reg, state_next;
    logic [1:0]                      mode_reg, mode_next;
    logic [3:0]                      retry_reg, retry_next;
    logic [TIMER_WIDTH-1:0]          elapsed_reg, elapsed_next;
    logic [amab_pkg::RAND_W-1:0]     target_reg, target_next;
    logic [7:0]                      pdest_reg, pdest_next;
    logic                            pmcast_reg, pmcast_next;
    logic [amab_pkg::RAND_W-1:0]     lfsr_reg, lfsr_next;
    logic [15:0]                     err_reg, err_next;
    logic [15:0]                     ack_reg, ack_next;

    // Result word held for the output channel.
    logic        o_acc_reg, o_acc_next;
    logic [1:0]  o_txk_reg, o_txk_next;
    logic [7:0]  o_txd_reg, o_txd_next;
    logic        o_dlv_reg, o_dlv_next;
    logic        o_gave_reg, o_gave_next;

    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;
    logic [amab_pkg::RAND_W-1:0] seed_load;
    logic                        s_fire;
    logic                        m_fire;

    logic                        div_start;
    logic                        div_busy;
    logic                        div_done;
    logic [amab_pkg::RAND_W-1:0] div_rem;
    logic [amab_pkg::RAND_W-1:0] lfsr_step;
    logic [amab_pkg::RAND_W-1:0] bound;
    logic [3:0]                  draw_exp;
    logic                        do_draw;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    // A zero seed would lock the LFSR, so it is replaced by one.
    assign seed_load = (pwdata[15:0] == '0) ? amab_pkg::RAND_W'(1) : pwdata[15:0];

    // Galois LFSR advance, used once per backoff draw.
    assign lfsr_step = {1'b0, lfsr_reg[amab_pkg::RAND_W-1:1]}
                     ^ (lfsr_reg[0] ? amab_pkg::LFSR_TAPS : '0);

    // Window doubled per retry; at most 255 << 7, so it fits 16 bits.
    assign bound = amab_pkg::RAND_W'({8'd0, window_reg} << draw_exp);

    // Configuration writes and reads.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_address_reg   <= 8'd1;
            my_group_reg     <= 8'd0;
            window_reg       <= 8'd16;
            ack_timeout_reg  <= 16'd100;
            max_attempts_reg <= 4'd3;
            seed_reg         <= 16'd44257;
        end else if (cfg_wr) begin
            case (cfg_idx)
                amab_pkg::REG_MY_ADDRESS:  my_address_reg   <= pwdata[7:0];
                amab_pkg::REG_MY_GROUP:    my_group_reg     <= pwdata[7:0];
                amab_pkg::REG_WINDOW:      window_reg       <= pwdata[7:0];
                amab_pkg::REG_ACK_TIMEOUT: ack_timeout_reg  <= pwdata[15:0];
                amab_pkg::REG_MAX_ATTEMPT: max_attempts_reg <= pwdata[3:0];
                amab_pkg::REG_SEED:        seed_reg         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            amab_pkg::REG_MY_ADDRESS:  prdata = {24'd0, my_address_reg};
            amab_pkg::REG_MY_GROUP:    prdata = {24'd0, my_group_reg};
            amab_pkg::REG_WINDOW:      prdata = {24'd0, window_reg};
            amab_pkg::REG_ACK_TIMEOUT: prdata = {16'd0, ack_timeout_reg};
            amab_pkg::REG_MAX_ATTEMPT: prdata = {28'd0, max_attempts_reg};
            amab_pkg::REG_SEED:        prdata = {16'd0, seed_reg};
            default:                   prdata = '0;
        endcase
    end

    // Decision logic. Everything except the backoff remainder is settled in the
    // cycle the word is accepted; the remainder is written back when the
    // remainder unit finishes.
    always_comb begin
        logic       for_me;
        logic [3:0] limit;
        logic       retry_path;

        state_next   = state_reg;
        mode_next    = mode_reg;
        retry_next   = retry_reg;
        elapsed_next = elapsed_reg;
        target_next  = target_reg;
        pdest_next   = pdest_reg;
        pmcast_next  = pmcast_reg;
        lfsr_next    = lfsr_reg;
        err_next     = err_reg;
        ack_next     = ack_reg;
        o_acc_next   = o_acc_reg;
        o_txk_next   = o_txk_reg;
        o_txd_next   = o_txd_reg;
        o_dlv_next   = o_dlv_reg;
        o_gave_next  = o_gave_reg;
        do_draw      = 1'b0;
        draw_exp     = 4'd0;
        retry_path   = 1'b0;
        div_start    = 1'b0;

        for_me = (s_frame_dest == my_address_reg) ||
                 (s_frame_group == my_group_reg && s_frame_dest == amab_pkg::MCAST_ADDR);
        limit  = (max_attempts_reg > amab_pkg::MAX_EXP) ? amab_pkg::MAX_EXP
                                                         : max_attempts_reg;

        // A seed write reloads the LFSR; the user makes writes only while idle, unchecked.
        if (cfg_wr && cfg_idx == amab_pkg::REG_SEED) begin
            lfsr_next = seed_load;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    o_acc_next  = 1'b0;
                    o_txk_next  = amab_pkg::TX_NONE;
                    o_txd_next  = 8'd0;
                    o_dlv_next  = 1'b0;
                    o_gave_next = 1'b0;

                    case (s_kind)
                        amab_pkg::KIND_TICK: begin
                            if (mode_reg == amab_pkg::MODE_BACKOFF &&
                                CMP_W'(elapsed_reg) >= CMP_W'(target_reg)) begin
                                o_txk_next   = amab_pkg::TX_FRAME;
                                o_txd_next   = pdest_reg;
                                elapsed_next = '0;
                                mode_next    = pmcast_reg ? amab_pkg::MODE_IDLE
                                                          : amab_pkg::MODE_ACKWAIT;
                            end else if (mode_reg == amab_pkg::MODE_ACKWAIT &&
                                CMP_W'(elapsed_reg) >= CMP_W'(ack_timeout_reg)) begin
                                retry_path = 1'b1;
                            end else if (elapsed_reg != {TIMER_WIDTH{1'b1}}) begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                        end
                        amab_pkg::KIND_REQUEST: begin
                            if (mode_reg == amab_pkg::MODE_IDLE) begin
                                o_acc_next   = 1'b1;
                                pdest_next   = s_request_dest;
                                pmcast_next  = (s_request_dest == amab_pkg::MCAST_ADDR);
                                retry_next   = 4'd0;
                                do_draw      = 1'b1;
                                draw_exp     = 4'd0;
                                elapsed_next = '0;
                                mode_next    = amab_pkg::MODE_BACKOFF;
                            end
                        end
                        amab_pkg::KIND_FRAME: begin
                            if (s_frame_status != amab_pkg::FST_GOOD) begin
                                err_next = err_reg + 1'b1;
                            end
                            if (s_frame_status == amab_pkg::FST_BAD) begin
                                if (for_me) begin
                                    if (mode_reg == amab_pkg::MODE_ACKWAIT) begin
                                        retry_path = 1'b1;
                                    end
                                    if (s_frame_type == amab_pkg::FTYPE_MSG &&
                                        s_frame_dest == amab_pkg::MCAST_ADDR) begin
                                        o_txk_next = amab_pkg::TX_NACK;
                                        o_txd_next = s_frame_source;
                                    end
                                end
                            end else if (s_frame_status == amab_pkg::FST_GOOD && for_me) begin
                                case (s_frame_type)
                                    amab_pkg::FTYPE_MSG: begin
                                        o_dlv_next = 1'b1;
                                        if (s_frame_dest != amab_pkg::MCAST_ADDR) begin
                                            o_txk_next = amab_pkg::TX_ACK;
                                            o_txd_next = s_frame_source;
                                        end
                                    end
                                    amab_pkg::FTYPE_ACK: begin
                                        ack_next = ack_reg + 1'b1;
                                        if (mode_reg == amab_pkg::MODE_ACKWAIT ||
                                            mode_reg == amab_pkg::MODE_BACKOFF) begin
                                            mode_next  = amab_pkg::MODE_IDLE;
                                            retry_next = 4'd0;
                                        end
                                    end
                                    amab_pkg::FTYPE_NACK: begin
                                        o_txk_next = amab_pkg::TX_FRAME;
                                        o_txd_next = pdest_reg;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase

                    // Retry with a fresh backoff, or drop the frame at the limit.
                    if (retry_path) begin
                        if (retry_reg < limit) begin
                            do_draw      = 1'b1;
                            draw_exp     = retry_reg;
                            elapsed_next = '0;
                            retry_next   = retry_reg + 1'b1;
                            mode_next    = amab_pkg::MODE_BACKOFF;
                        end else begin
                            retry_next  = 4'd0;
                            mode_next   = amab_pkg::MODE_IDLE;
                            o_gave_next = 1'b1;
                        end
                    end

                    if (do_draw) begin
                        lfsr_next = lfsr_step;
                        if (bound == '0) begin
                            target_next = '0;
                            state_next  = ST_OUT;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DRAW;
                        end
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DRAW: begin
                if (div_done) begin
                    target_next = div_rem;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= amab_pkg::MODE_IDLE;
            retry_reg   <= 4'd0;
            elapsed_reg <= '0;
            target_reg  <= '0;
            pdest_reg   <= 8'd0;
            pmcast_reg  <= 1'b0;
            lfsr_reg    <= 16'd44257;
            err_reg     <= 16'd0;
            ack_reg     <= 16'd0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            retry_reg   <= retry_next;
            elapsed_reg <= elapsed_next;
            target_reg  <= target_next;
            pdest_reg   <= pdest_next;
            pmcast_reg  <= pmcast_next;
            lfsr_reg    <= lfsr_next;
            err_reg     <= err_next;
            ack_reg     <= ack_next;
        end
        o_acc_reg  <= o_acc_next;
        o_txk_reg  <= o_txk_next;
        o_txd_reg  <= o_txd_next;
        o_dlv_reg  <= o_dlv_next;
        o_gave_reg <= o_gave_next;
    end

    // The remainder of the advanced LFSR value by the window bound is the
    // new backoff target.
    amab_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (lfsr_step),
        .divisor   (bound),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // The status fields show the controller state after the word, which does
    // not change while the result waits.
    assign m_request_accepted = o_acc_reg;
    assign m_tx_kind          = o_txk_reg;
    assign m_tx_dest          = o_txd_reg;
    assign m_deliver          = o_dlv_reg;
    assign m_gave_up          = o_gave_reg;
    assign m_mac_status       = mode_reg;
    assign m_retry_now        = retry_reg;
    assign m_error_total      = err_reg;
    assign m_ack_total        = ack_reg;

`ifndef ASSERT_OFF
    a_ready_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy)
        else $error("input ready while the remainder unit is busy");

    a_done_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |=> (state_reg == ST_OUT))
        else $error("backoff draw finished without presenting a result");

    a_retry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        retry_reg <= amab_pkg::MAX_EXP)
        else $error("retry count above the exponent cap");

    a_no_tx_no_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_kind == amab_pkg::TX_NONE) |-> (m_tx_dest == 8'd0))
        else $error("destination set on a word with no transmission");
`endif

endmodule
